// ----- sv/bth_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bth_pkg
// shared types, codes and constants of the boundary-tag heap allocator
// ----------------------------------------------------------------------------
package bth_pkg;

    localparam int HEAP_WORDS_DEF = 16384;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_CHUNK = 1'd1;
    localparam logic [CFG_DATA_W-1:0] HEAP_LIMIT_RST = 17'd65536;
    localparam logic [CFG_DATA_W-1:0] GROW_CHUNK_RST = 17'd4096;

    // function codes
    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_FREE  = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

    // tag layout
    localparam logic [31:0] WSIZE        = 32'd4;
    localparam logic [31:0] DSIZE        = 32'd8;
    localparam logic [31:0] MIN_BLOCK    = 32'd16;
    localparam logic [31:0] TAG_USED     = 32'd1;
    localparam logic [31:0] PROLOGUE_TAG = DSIZE | TAG_USED;
    localparam logic [31:0] EPILOGUE_TAG = TAG_USED;
    localparam logic [31:0] HEAP_BYTES_MAX = 32'd65536;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] request_size;
        logic [15:0] block_address;
    } in_word_t;

    typedef struct packed {
        logic [15:0] payload_address;
        logic [16:0] granted_size;
        logic [1:0]  status;
    } out_word_t;

    // datapath micro-operations
    typedef enum logic [5:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_INIT0,
        CMD_INIT1,
        CMD_INIT2,
        CMD_INIT3,
        CMD_GROW_CHK,
        CMD_GROW_W1,
        CMD_GROW_W2,
        CMD_GROW_W3,
        CMD_MRG_RD_OWN,
        CMD_MRG_RD_PREV,
        CMD_MRG_RD_NEXT,
        CMD_MRG_EVAL,
        CMD_MRG_N_W1,
        CMD_MRG_N_W2,
        CMD_MRG_RD_PRV,
        CMD_MRG_P_W1,
        CMD_MRG_P_W2,
        CMD_SRCH_START,
        CMD_SRCH_WRAP,
        CMD_SRCH_MISS,
        CMD_SRCH_RD,
        CMD_SRCH_ADV,
        CMD_SRCH_HIT,
        CMD_PLC_RD,
        CMD_PLC_W1,
        CMD_PLC_W2,
        CMD_PLC_W3,
        CMD_PLC_W4,
        CMD_FREE_RD,
        CMD_FREE_W1,
        CMD_FREE_W2,
        CMD_RES_NULL,
        CMD_RES_OOM,
        CMD_RES_INIT,
        CMD_RES_GRANT,
        CMD_RES_ZERO,
        CMD_EMIT
    } cmd_t;

    // datapath flags seen by the controller
    typedef struct packed {
        logic [1:0] func;
        logic       req_zero;
        logic       base_zero;
        logic       free_pre;
        logic       free_ok;
        logic       gfail;
        logic       stop;
        logic       phase;
        logic       sz_zero;
        logic       fit;
        logic       pfree;
        logic       nfree;
        logic       split;
        logic       out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/bth_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bth_ctrl
// sequencer that steps the datapath through init, allocate and free
// ----------------------------------------------------------------------------
module bth_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bth_pkg::dp_stat_t stat,
    output bth_pkg::cmd_t        cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_INIT1, S_INIT2, S_INIT3,
        S_GROW_CHK, S_GROW_DEC, S_GROW_W2, S_GROW_W3,
        S_M_OWN, S_M_PREV, S_M_NEXT, S_M_EVAL, S_M_DEC, S_M_N2, S_M_P1, S_M_P2,
        S_MRET, S_GRET, S_A_CHK, S_A_EVAL,
        S_P_RD, S_P_W1, S_P_W2, S_P_W3, S_P_W4, S_P_FIN,
        S_F_CHK, S_F_W2, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = bth_pkg::CMD_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = bth_pkg::CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.func)
                    bth_pkg::FUNC_INIT:
                    begin
                        cmd        = bth_pkg::CMD_INIT0;
                        state_next = S_INIT1;
                    end
                    bth_pkg::FUNC_ALLOC:
                    begin
                        if (stat.req_zero)
                        begin
                            cmd        = bth_pkg::CMD_RES_NULL;
                            state_next = S_EMIT;
                        end
                        else if (stat.base_zero)
                        begin
                            cmd        = bth_pkg::CMD_RES_OOM;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd        = bth_pkg::CMD_SRCH_START;
                            state_next = S_A_CHK;
                        end
                    end
                    bth_pkg::FUNC_FREE:
                    begin
                        if (stat.free_pre)
                        begin
                            cmd        = bth_pkg::CMD_FREE_RD;
                            state_next = S_F_CHK;
                        end
                        else
                        begin
                            cmd        = bth_pkg::CMD_RES_ZERO;
                            state_next = S_EMIT;
                        end
                    end
                    default:
                    begin
                        cmd        = bth_pkg::CMD_RES_ZERO;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_INIT1:
            begin
                cmd        = bth_pkg::CMD_INIT1;
                state_next = S_INIT2;
            end
            S_INIT2:
            begin
                cmd        = bth_pkg::CMD_INIT2;
                state_next = S_INIT3;
            end
            S_INIT3:
            begin
                cmd        = bth_pkg::CMD_INIT3;
                state_next = S_GROW_CHK;
            end
            S_GROW_CHK:
            begin
                cmd        = bth_pkg::CMD_GROW_CHK;
                state_next = S_GROW_DEC;
            end
            S_GROW_DEC:
            begin
                if (stat.gfail)
                begin
                    state_next = S_GRET;
                end
                else
                begin
                    cmd        = bth_pkg::CMD_GROW_W1;
                    state_next = S_GROW_W2;
                end
            end
            S_GROW_W2:
            begin
                cmd        = bth_pkg::CMD_GROW_W2;
                state_next = S_GROW_W3;
            end
            S_GROW_W3:
            begin
                cmd        = bth_pkg::CMD_GROW_W3;
                state_next = S_M_OWN;
            end
            S_M_OWN:
            begin
                cmd        = bth_pkg::CMD_MRG_RD_OWN;
                state_next = S_M_PREV;
            end
            S_M_PREV:
            begin
                cmd        = bth_pkg::CMD_MRG_RD_PREV;
                state_next = S_M_NEXT;
            end
            S_M_NEXT:
            begin
                cmd        = bth_pkg::CMD_MRG_RD_NEXT;
                state_next = S_M_EVAL;
            end
            S_M_EVAL:
            begin
                cmd        = bth_pkg::CMD_MRG_EVAL;
                state_next = S_M_DEC;
            end
            S_M_DEC:
            begin
                if (!stat.pfree && !stat.nfree)
                begin
                    state_next = S_MRET;
                end
                else if (!stat.pfree)
                begin
                    cmd        = bth_pkg::CMD_MRG_N_W1;
                    state_next = S_M_N2;
                end
                else
                begin
                    cmd        = bth_pkg::CMD_MRG_RD_PRV;
                    state_next = S_M_P1;
                end
            end
            S_M_N2:
            begin
                cmd        = bth_pkg::CMD_MRG_N_W2;
                state_next = S_MRET;
            end
            S_M_P1:
            begin
                cmd        = bth_pkg::CMD_MRG_P_W1;
                state_next = S_M_P2;
            end
            S_M_P2:
            begin
                cmd        = bth_pkg::CMD_MRG_P_W2;
                state_next = S_MRET;
            end
            S_MRET:
            begin
                if (stat.func == bth_pkg::FUNC_FREE)
                begin
                    cmd        = bth_pkg::CMD_RES_ZERO;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_GRET;
                end
            end
            S_GRET:
            begin
                if (stat.func == bth_pkg::FUNC_INIT)
                begin
                    cmd        = bth_pkg::CMD_RES_INIT;
                    state_next = S_EMIT;
                end
                else if (stat.gfail)
                begin
                    cmd        = bth_pkg::CMD_RES_OOM;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_P_RD;
                end
            end
            S_A_CHK:
            begin
                if (stat.stop)
                begin
                    if (!stat.phase)
                    begin
                        cmd = bth_pkg::CMD_SRCH_WRAP;
                    end
                    else
                    begin
                        cmd        = bth_pkg::CMD_SRCH_MISS;
                        state_next = S_GROW_CHK;
                    end
                end
                else
                begin
                    cmd        = bth_pkg::CMD_SRCH_RD;
                    state_next = S_A_EVAL;
                end
            end
            S_A_EVAL:
            begin
                if (stat.sz_zero)
                begin
                    if (!stat.phase)
                    begin
                        cmd        = bth_pkg::CMD_SRCH_WRAP;
                        state_next = S_A_CHK;
                    end
                    else
                    begin
                        cmd        = bth_pkg::CMD_SRCH_MISS;
                        state_next = S_GROW_CHK;
                    end
                end
                else if (stat.fit)
                begin
                    cmd        = bth_pkg::CMD_SRCH_HIT;
                    state_next = S_P_RD;
                end
                else
                begin
                    cmd        = bth_pkg::CMD_SRCH_ADV;
                    state_next = S_A_CHK;
                end
            end
            S_P_RD:
            begin
                cmd        = bth_pkg::CMD_PLC_RD;
                state_next = S_P_W1;
            end
            S_P_W1:
            begin
                cmd        = bth_pkg::CMD_PLC_W1;
                state_next = S_P_W2;
            end
            S_P_W2:
            begin
                cmd        = bth_pkg::CMD_PLC_W2;
                state_next = stat.split ? S_P_W3 : S_P_FIN;
            end
            S_P_W3:
            begin
                cmd        = bth_pkg::CMD_PLC_W3;
                state_next = S_P_W4;
            end
            S_P_W4:
            begin
                cmd        = bth_pkg::CMD_PLC_W4;
                state_next = S_P_FIN;
            end
            S_P_FIN:
            begin
                cmd        = bth_pkg::CMD_RES_GRANT;
                state_next = S_EMIT;
            end
            S_F_CHK:
            begin
                if (stat.free_ok)
                begin
                    cmd        = bth_pkg::CMD_FREE_W1;
                    state_next = S_F_W2;
                end
                else
                begin
                    cmd        = bth_pkg::CMD_RES_ZERO;
                    state_next = S_EMIT;
                end
            end
            S_F_W2:
            begin
                cmd        = bth_pkg::CMD_FREE_W2;
                state_next = S_M_OWN;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd        = bth_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/bth_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bth_dp
// heap memory, heap registers and tag arithmetic driven by controller commands
// ----------------------------------------------------------------------------
module bth_dp #(
    parameter int HEAP_WORDS = bth_pkg::HEAP_WORDS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire bth_pkg::in_word_t                in_data,
    input  wire bth_pkg::cmd_t                    cmd,
    output bth_pkg::dp_stat_t                     stat,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output bth_pkg::out_word_t                    out_data,
    input  wire logic                             cfg_we,
    input  wire logic [bth_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bth_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam logic [31:0] MEM_BYTES = 32'(HEAP_WORDS * 4);
    localparam logic [31:0] LIM_CAP =
        (MEM_BYTES > bth_pkg::HEAP_BYTES_MAX) ? bth_pkg::HEAP_BYTES_MAX : MEM_BYTES;

    // heap memory
    logic [31:0]   mem [HEAP_WORDS];
    logic [31:0]   mem_q_reg;
    logic          oor_q_reg;
    logic [31:0]   mem_addr;
    logic          mem_we;
    logic [31:0]   mem_wdata;
    logic          mem_oor;
    logic [AW-1:0] mem_idx;
    logic [31:0]   mem_rd;
    logic [31:0]   rd_size;
    logic          rd_used;

    // heap registers
    logic [16:0] brk_reg;
    logic [15:0] base_reg;
    logic [15:0] rover_reg;
    logic        rvalid_reg;
    logic [16:0] limit_reg;
    logic [16:0] chunk_reg;
    logic        out_valid_reg;
    bth_pkg::out_word_t out_reg;

    // working registers
    bth_pkg::in_word_t in_reg;
    bth_pkg::out_word_t res_reg;
    logic [31:0] bp_reg;
    logic [15:0] start_reg;
    logic [31:0] asize_reg;
    logic [16:0] grow_bytes_reg;
    logic [31:0] gsize_reg;
    logic [31:0] own_reg;
    logic [31:0] nxt_reg;
    logic [31:0] psz_reg;
    logic [31:0] nsz_reg;
    logic [31:0] prv_reg;
    logic [31:0] size_reg;
    logic [31:0] csize_reg;
    logic        gfail_reg;
    logic        phase_reg;
    logic        split_reg;
    logic        pfree_reg;
    logic        nfree_reg;

    // combinational helpers
    logic [31:0] cur_limit;
    logic [31:0] gwords;
    logic [31:0] gsz_raw;
    logic [31:0] gsz_calc;
    logic [31:0] asize_calc;
    logic [15:0] start_calc;
    logic [31:0] bsz;
    logic        split_now;
    logic [31:0] p_sum;
    logic [31:0] chunk_ext;
    logic [31:0] addr_ext;

    assign mem_oor = (mem_addr >= MEM_BYTES);
    assign mem_idx = mem_addr[AW+1:2];
    assign mem_rd  = oor_q_reg ? 32'd0 : mem_q_reg;
    assign rd_size = {mem_rd[31:3], 3'b000};
    assign rd_used = mem_rd[0];

    assign addr_ext   = {16'd0, in_reg.block_address};
    assign chunk_ext  = {15'd0, chunk_reg};
    assign cur_limit  = ({15'd0, limit_reg} > LIM_CAP) ? LIM_CAP : {15'd0, limit_reg};
    assign gwords     = ({17'd0, grow_bytes_reg[16:2]} + 32'd1) & ~32'd1;
    assign gsz_raw    = {gwords[29:0], 2'b00};
    assign gsz_calc   = (gsz_raw < bth_pkg::MIN_BLOCK) ? bth_pkg::MIN_BLOCK : gsz_raw;
    assign asize_calc = (in_reg.request_size <= 16'd8) ? bth_pkg::MIN_BLOCK
                      : ({16'd0, in_reg.request_size} + 32'd15) & ~32'd7;
    assign start_calc = rvalid_reg ? rover_reg : base_reg;
    assign split_now  = (rd_size >= asize_reg) && ((rd_size - asize_reg) >= bth_pkg::MIN_BLOCK);
    assign bsz        = split_reg ? asize_reg : csize_reg;
    assign p_sum      = own_reg + rd_size + (nfree_reg ? nsz_reg : 32'd0);

    // memory access of the current command
    always_comb
    begin
        mem_addr  = bp_reg - bth_pkg::WSIZE;
        mem_we    = 1'b0;
        mem_wdata = 32'd0;
        unique case (cmd)
            bth_pkg::CMD_INIT0:
            begin
                mem_addr = 32'd0;
                mem_we   = 1'b1;
            end
            bth_pkg::CMD_INIT1:
            begin
                mem_addr  = bth_pkg::WSIZE;
                mem_we    = 1'b1;
                mem_wdata = bth_pkg::PROLOGUE_TAG;
            end
            bth_pkg::CMD_INIT2:
            begin
                mem_addr  = bth_pkg::DSIZE;
                mem_we    = 1'b1;
                mem_wdata = bth_pkg::PROLOGUE_TAG;
            end
            bth_pkg::CMD_INIT3:
            begin
                mem_addr  = bth_pkg::DSIZE + bth_pkg::WSIZE;
                mem_we    = 1'b1;
                mem_wdata = bth_pkg::EPILOGUE_TAG;
            end
            bth_pkg::CMD_GROW_W1:
            begin
                mem_we    = 1'b1;
                mem_wdata = gsize_reg;
            end
            bth_pkg::CMD_GROW_W2:
            begin
                mem_addr  = bp_reg + gsize_reg - bth_pkg::DSIZE;
                mem_we    = 1'b1;
                mem_wdata = gsize_reg;
            end
            bth_pkg::CMD_GROW_W3:
            begin
                mem_addr  = bp_reg + gsize_reg - bth_pkg::WSIZE;
                mem_we    = 1'b1;
                mem_wdata = bth_pkg::EPILOGUE_TAG;
            end
            bth_pkg::CMD_MRG_RD_PREV:
            begin
                mem_addr = bp_reg - bth_pkg::DSIZE;
            end
            bth_pkg::CMD_MRG_RD_NEXT:
            begin
                mem_addr = nxt_reg - bth_pkg::WSIZE;
            end
            bth_pkg::CMD_MRG_N_W1:
            begin
                mem_we    = 1'b1;
                mem_wdata = own_reg + nsz_reg;
            end
            bth_pkg::CMD_MRG_N_W2:
            begin
                mem_addr  = bp_reg + size_reg - bth_pkg::DSIZE;
                mem_we    = 1'b1;
                mem_wdata = size_reg;
            end
            bth_pkg::CMD_MRG_RD_PRV:
            begin
                mem_addr = bp_reg - psz_reg - bth_pkg::WSIZE;
            end
            bth_pkg::CMD_MRG_P_W1:
            begin
                mem_addr  = nfree_reg ? (prv_reg - bth_pkg::WSIZE)
                                      : (bp_reg + own_reg - bth_pkg::DSIZE);
                mem_we    = 1'b1;
                mem_wdata = p_sum;
            end
            bth_pkg::CMD_MRG_P_W2:
            begin
                mem_addr  = nfree_reg ? (nxt_reg + nsz_reg - bth_pkg::DSIZE)
                                      : (prv_reg - bth_pkg::WSIZE);
                mem_we    = 1'b1;
                mem_wdata = size_reg;
            end
            bth_pkg::CMD_PLC_W1:
            begin
                mem_we    = 1'b1;
                mem_wdata = (split_now ? asize_reg : rd_size) | bth_pkg::TAG_USED;
            end
            bth_pkg::CMD_PLC_W2:
            begin
                mem_addr  = bp_reg + bsz - bth_pkg::DSIZE;
                mem_we    = 1'b1;
                mem_wdata = bsz | bth_pkg::TAG_USED;
            end
            bth_pkg::CMD_PLC_W3:
            begin
                mem_addr  = bp_reg + asize_reg - bth_pkg::WSIZE;
                mem_we    = 1'b1;
                mem_wdata = csize_reg - asize_reg;
            end
            bth_pkg::CMD_PLC_W4:
            begin
                mem_addr  = bp_reg + csize_reg - bth_pkg::DSIZE;
                mem_we    = 1'b1;
                mem_wdata = csize_reg - asize_reg;
            end
            bth_pkg::CMD_FREE_RD:
            begin
                mem_addr = addr_ext - bth_pkg::WSIZE;
            end
            bth_pkg::CMD_FREE_W1:
            begin
                mem_addr  = addr_ext - bth_pkg::WSIZE;
                mem_we    = 1'b1;
                mem_wdata = rd_size;
            end
            bth_pkg::CMD_FREE_W2:
            begin
                mem_addr  = addr_ext + size_reg - bth_pkg::DSIZE;
                mem_we    = 1'b1;
                mem_wdata = size_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && !mem_oor)
        begin
            mem[mem_idx] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_idx];
        oor_q_reg <= mem_oor;
    end

    // heap control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brk_reg       <= '0;
            base_reg      <= '0;
            rover_reg     <= '0;
            rvalid_reg    <= 1'b0;
            limit_reg     <= bth_pkg::HEAP_LIMIT_RST;
            chunk_reg     <= bth_pkg::GROW_CHUNK_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == bth_pkg::CFG_HEAP_LIMIT)
                begin
                    limit_reg <= cfg_data;
                end
                if (cfg_index == bth_pkg::CFG_GROW_CHUNK)
                begin
                    chunk_reg <= cfg_data;
                end
            end
            if (cmd == bth_pkg::CMD_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd)
                bth_pkg::CMD_INIT0:
                begin
                    brk_reg    <= '0;
                    rvalid_reg <= 1'b0;
                    rover_reg  <= '0;
                end
                bth_pkg::CMD_INIT3:
                begin
                    brk_reg  <= 17'(bth_pkg::MIN_BLOCK);
                    base_reg <= 16'(bth_pkg::DSIZE);
                end
                bth_pkg::CMD_GROW_W3:
                begin
                    brk_reg <= 17'(bp_reg + gsize_reg);
                end
                bth_pkg::CMD_MRG_N_W2:
                begin
                    rover_reg  <= bp_reg[15:0];
                    rvalid_reg <= 1'b1;
                end
                bth_pkg::CMD_MRG_P_W2:
                begin
                    rover_reg  <= prv_reg[15:0];
                    rvalid_reg <= 1'b1;
                end
                bth_pkg::CMD_SRCH_START:
                begin
                    rover_reg  <= start_calc;
                    rvalid_reg <= 1'b1;
                end
                bth_pkg::CMD_SRCH_HIT:
                begin
                    rover_reg <= bp_reg[15:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            bth_pkg::CMD_LOAD:
            begin
                in_reg <= in_data;
            end
            bth_pkg::CMD_INIT3:
            begin
                grow_bytes_reg <= chunk_reg;
            end
            bth_pkg::CMD_GROW_CHK:
            begin
                gsize_reg <= gsz_calc;
                bp_reg    <= {15'd0, brk_reg};
                gfail_reg <= (({15'd0, brk_reg} + gsz_calc) > cur_limit);
            end
            bth_pkg::CMD_MRG_RD_PREV:
            begin
                own_reg <= rd_size;
                nxt_reg <= bp_reg + rd_size;
            end
            bth_pkg::CMD_MRG_RD_NEXT:
            begin
                psz_reg   <= rd_size;
                pfree_reg <= !rd_used;
            end
            bth_pkg::CMD_MRG_EVAL:
            begin
                nsz_reg   <= rd_size;
                nfree_reg <= !rd_used;
            end
            bth_pkg::CMD_MRG_N_W1:
            begin
                size_reg <= own_reg + nsz_reg;
            end
            bth_pkg::CMD_MRG_RD_PRV:
            begin
                prv_reg <= bp_reg - psz_reg;
            end
            bth_pkg::CMD_MRG_P_W1:
            begin
                size_reg <= p_sum;
            end
            bth_pkg::CMD_MRG_P_W2:
            begin
                bp_reg <= prv_reg;
            end
            bth_pkg::CMD_SRCH_START:
            begin
                asize_reg <= asize_calc;
                start_reg <= start_calc;
                bp_reg    <= {16'd0, start_calc};
                phase_reg <= 1'b0;
            end
            bth_pkg::CMD_SRCH_WRAP:
            begin
                phase_reg <= 1'b1;
                bp_reg    <= {16'd0, base_reg};
            end
            bth_pkg::CMD_SRCH_MISS:
            begin
                grow_bytes_reg <= (asize_reg > chunk_ext) ? asize_reg[16:0] : chunk_reg;
            end
            bth_pkg::CMD_SRCH_ADV:
            begin
                bp_reg <= bp_reg + rd_size;
            end
            bth_pkg::CMD_PLC_W1:
            begin
                csize_reg <= rd_size;
                split_reg <= split_now;
            end
            bth_pkg::CMD_FREE_W1:
            begin
                size_reg <= rd_size;
                bp_reg   <= addr_ext;
            end
            bth_pkg::CMD_RES_NULL:
            begin
                res_reg <= '{payload_address: '0, granted_size: '0, status: bth_pkg::ST_NULL};
            end
            bth_pkg::CMD_RES_OOM:
            begin
                res_reg <= '{payload_address: '0, granted_size: '0, status: bth_pkg::ST_OOM};
            end
            bth_pkg::CMD_RES_INIT:
            begin
                res_reg <= '{payload_address: '0, granted_size: '0,
                             status: (gfail_reg ? bth_pkg::ST_OOM : bth_pkg::ST_DONE)};
            end
            bth_pkg::CMD_RES_GRANT:
            begin
                res_reg <= '{payload_address: bp_reg[15:0], granted_size: bsz[16:0],
                             status: bth_pkg::ST_DONE};
            end
            bth_pkg::CMD_RES_ZERO:
            begin
                res_reg <= '{payload_address: '0, granted_size: '0, status: bth_pkg::ST_DONE};
            end
            bth_pkg::CMD_EMIT:
            begin
                out_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end

    // flags for the controller
    always_comb
    begin
        stat.func      = in_reg.func;
        stat.req_zero  = (in_reg.request_size == 16'd0);
        stat.base_zero = (base_reg == 16'd0);
        stat.free_pre  = (base_reg != 16'd0) && (in_reg.block_address[2:0] == 3'd0)
                      && (in_reg.block_address > base_reg);
        stat.free_ok   = rd_used && (rd_size >= bth_pkg::MIN_BLOCK)
                      && ((addr_ext + rd_size) <= {15'd0, brk_reg});
        stat.gfail     = gfail_reg;
        stat.stop      = (phase_reg && (bp_reg == {16'd0, start_reg}))
                      || !((bp_reg - bth_pkg::WSIZE) < {15'd0, brk_reg});
        stat.phase     = phase_reg;
        stat.sz_zero   = (rd_size == 32'd0);
        stat.fit       = !rd_used && (asize_reg <= rd_size);
        stat.pfree     = pfree_reg;
        stat.nfree     = nfree_reg;
        stat.split     = split_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == bth_pkg::CMD_EMIT) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while still waiting");

    a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({15'd0, brk_reg} <= LIM_CAP) && (brk_reg[2:0] == 3'd0))
        else $error("break outside heap or misaligned");

    a_rover_base: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> (base_reg != 16'd0))
        else $error("rover live before heap init");

    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != bth_pkg::ST_DONE)) |->
        ((out_reg.granted_size == 17'd0) && (out_reg.payload_address == 16'd0)))
        else $error("grant reported with failure status");
`endif

endmodule
`default_nettype wire

// ----- sv/boundary_tag_heap_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// next-fit heap allocator with size/used boundary tags over a word memory
// ----------------------------------------------------------------------------
//  channel   dir   handshake              word
//  in        in    in_valid / in_ready    in_data  (func, request_size, block_address)
//  out       out   out_valid / out_ready  out_data (payload_address, granted_size, status)
//  cfg       in    cfg_we                 cfg_index, cfg_data (heap limit, grow chunk)
//
//  one item at a time; the single-port heap memory does one access per cycle
//  init writes the prologue and epilogue tags, then grows the heap once;
//  free retags a valid used block as free and coalesces it, else is ignored;
//  allocate walks block headers from the rover, wraps once to the heap base,
//  and on a miss grows the heap, coalesces, then places the block
//  a finished word sits in the output register while the next item is taken;
//  a full output register holds the sequencer before the emit, stalling input
//  asynchronous active-low reset; heap memory contents are not cleared
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator #(
    parameter int HEAP_WORDS = bth_pkg::HEAP_WORDS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire bth_pkg::in_word_t                in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output bth_pkg::out_word_t                    out_data,
    input  wire logic                             cfg_we,
    input  wire logic [bth_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bth_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // command bus from sequencer, flag bundle back from datapath
    bth_pkg::cmd_t     cmd;
    bth_pkg::dp_stat_t stat;

    // sequencer: walks init, search, grow, coalesce and placement steps
    bth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: heap memory, break/base/rover, tag math and output register
    bth_dp #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire
